FILE: src/assert_macros.svh
// Assertion macros shared by the core and window RTL files.
// Each macro takes a label, the clock, the reset, the property and the message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SRMS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SRMS_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define SRMS_ASSERT(lbl, clk, rst, prop, msg)
`define SRMS_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

FILE: src/srms_pkg.sv
package srms_pkg;

  // Window and sample geometry.
  localparam int WINDOW      = 4800;
  localparam int SAMPLE_BITS = 24;
  localparam int POS_W       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int MAG_W       = SAMPLE_BITS - 1;
  localparam int SQ_W        = 2 * SAMPLE_BITS - 2;

  // Port widths.
  localparam int IN_W  = 24;
  localparam int OUT_W = 17;
  localparam int CFG_W = 16;

  localparam logic [CFG_W-1:0] INTERVAL_RESET = 16'd301;

  // Running sum and logarithm geometry.
  localparam int SUM_W    = 59;
  localparam int PAD_W    = 64;
  localparam int CHUNK_W  = 8;
  localparam int N_CHUNK  = PAD_W / CHUNK_W;
  localparam int CPOS_W   = $clog2(CHUNK_W);
  localparam int TOP_W    = $clog2(PAD_W);
  localparam int FRAC_W   = 16;
  localparam int MANT_W   = 32;
  localparam int L2_W     = TOP_W + FRAC_W;
  localparam int D_W      = 24;

  // Scale from a Q.16 base-2 log to 1/256 dB, in Q.16 of that unit.
  localparam int LOG_SCALE_W = 26;
  localparam logic [LOG_SCALE_W-1:0] LOG_SCALE = 26'd50504453;
  localparam int PROD_W = D_W + LOG_SCALE_W;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << 31);

  localparam logic signed [OUT_W-1:0] LEVEL_FLOOR = -17'sd65536;

  // Q.16 base-2 logarithm, evaluated at elaboration only.
  function automatic logic [63:0] log2_q16_const(input logic [63:0] x);
    logic [63:0] m;
    logic [63:0] frac;
    int          top;
    top  = 0;
    frac = '0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) top = i;
    end
    if (top >= 31) m = x >> (top - 31);
    else m = x << (31 - top);
    for (int i = 0; i < FRAC_W; i++) begin
      m    = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        m    = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return 64'(top) * 64'd65536 + frac;
  endfunction

  // Log of WINDOW times full scale squared.
  localparam logic [D_W-1:0] FULL_Q16 =
    D_W'(log2_q16_const(64'(WINDOW)) + 64'(2 * SAMPLE_BITS - 2) * 64'd65536);

  // A sum handed from the ring stage to the log pipeline.
  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
  } srms_rpt_t;

  // A finished level from the log pipeline.
  typedef struct packed {
    logic                    valid;
    logic signed [OUT_W-1:0] level;
  } srms_lvl_t;

endpackage

FILE: src/sliding_rms_level_meter_core.sv
// A reporting word passes the square, sum, log pipeline and output registers. Unless
// stalled, one sample word per cycle; the ring memory is read and written once per
// sample and the 16-stage squaring log pipeline takes a new sum each cycle.
// The input stalls only while a finished level waits and another reaches the output.
// Reset (rst, synchronous, active high) empties the window, zeroes the report count
// and sets the report interval to 301; the ring needs no clearing pass.
`include "assert_macros.svh"

module sliding_rms_level_meter_core
  import srms_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_W-1:0]        report_interval,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [IN_W-1:0]  sample,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] level_db
);

  logic             adv;
  logic             accept;
  logic [CFG_W-1:0] interval;
  srms_rpt_t        rpt;
  srms_lvl_t        lvl;

  // The whole pipeline holds only when a new level would meet a full output.
  assign adv      = !(out_valid && !out_ready && lvl.valid);
  assign in_ready = adv;
  assign accept   = in_valid && in_ready;

  // Configuration register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= INTERVAL_RESET;
    end else if (cfg_valid) begin
      interval <= report_interval;
    end
  end

  srms_window u_window (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .accept   (accept),
    .sample   (sample),
    .interval (interval),
    .rpt      (rpt)
  );

  srms_log2 u_log2 (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .rpt (rpt),
    .lvl (lvl)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && lvl.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && lvl.valid) begin
      level_db <= lvl.level;
    end
  end

  `SRMS_ASSERT(a_stall_cause, clk, rst, !in_ready |-> out_valid && !out_ready && lvl.valid, "Input stalled without a blocked level.")
  `SRMS_ASSERT(a_level_range, clk, rst, out_valid |-> level_db[OUT_W-1] || (level_db == '0), "Level above full scale.")

endmodule

FILE: src/srms_ram.sv
module srms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // One write port, one registered read port; a read of the entry being
  // written returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/srms_window.sv
`include "assert_macros.svh"

module srms_window
  import srms_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    accept,
  input  logic signed [IN_W-1:0]  sample,
  input  logic [CFG_W-1:0]        interval,
  output srms_rpt_t               rpt
);

  logic [SAMPLE_BITS-1:0] raw;
  logic [SAMPLE_BITS-1:0] abs_val;
  logic                   is_min;
  logic [MAG_W-1:0]       mag;
  logic [SQ_W-1:0]        sq;

  logic [POS_W-1:0] pos;
  logic             filled;
  logic [CFG_W-1:0] count;
  logic [CFG_W-1:0] count_inc;
  logic             report_now;
  logic             pos_last;

  logic             s1_valid;
  logic [SQ_W-1:0]  s1_sq;
  logic [POS_W-1:0] s1_addr;
  logic             s1_fwd;
  logic [SQ_W-1:0]  s1_fwd_data;
  logic             s1_zero;
  logic             s1_report;

  logic [SQ_W-1:0]  rd_data;
  logic [SQ_W-1:0]  old_sq;
  logic [SUM_W-1:0] window_sum;
  logic [SUM_W-1:0] window_sum_next;
  logic             ram_we;

  // Clamp the most negative code and square the magnitude.
  assign raw     = sample[SAMPLE_BITS-1:0];
  assign is_min  = (raw == {1'b1, {MAG_W{1'b0}}});
  assign abs_val = raw[SAMPLE_BITS-1] ? SAMPLE_BITS'(~raw + 1'b1) : raw;
  assign mag     = is_min ? {MAG_W{1'b1}} : abs_val[MAG_W-1:0];
  assign sq      = SQ_W'(mag) * SQ_W'(mag);

  // Report counter decision for the word being accepted.
  assign count_inc  = count + 1'b1;
  assign report_now = !(count_inc < interval);
  assign pos_last   = (pos == POS_W'(WINDOW - 1));

  // Ring pointer, fill flag and report counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      filled <= 1'b0;
      count  <= '0;
    end else if (accept) begin
      if (pos_last) begin
        pos    <= '0;
        filled <= 1'b1;
      end else begin
        pos <= pos + 1'b1;
      end
      count <= report_now ? '0 : count_inc;
    end
  end

  // Square stage; the ring is read here for the entry about to be replaced.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sq       <= sq;
      s1_addr     <= pos;
      s1_fwd      <= s1_valid && (s1_addr == pos);
      s1_fwd_data <= s1_sq;
      s1_zero     <= !filled;
      s1_report   <= report_now;
    end
  end

  assign ram_we = adv && s1_valid;

  srms_ram #(
    .WIDTH (SQ_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (s1_sq),
    .re    (accept),
    .raddr (pos),
    .rdata (rd_data)
  );

  // Oldest square: forwarded when it was written in the same cycle as the
  // read, zero when the ring has not wrapped yet.
  always_comb begin
    priority if (s1_fwd) begin
      old_sq = s1_fwd_data;
    end else if (s1_zero) begin
      old_sq = '0;
    end else begin
      old_sq = rd_data;
    end
  end

  assign window_sum_next = window_sum + SUM_W'(s1_sq) - SUM_W'(old_sq);

  // Running sum and hand-off to the log pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum <= '0;
      rpt        <= '0;
    end else if (adv) begin
      if (s1_valid) begin
        window_sum <= window_sum_next;
      end
      rpt.valid <= s1_valid && s1_report;
      rpt.sum   <= window_sum_next;
    end
  end

  `SRMS_ASSERT(a_filled_sticky, clk, rst, filled |=> filled, "Fill flag dropped after the ring wrapped.")
  `SRMS_ASSERT(a_pos_wrap, clk, rst, accept && pos_last |=> (pos == '0) && filled, "Ring pointer did not wrap to zero.")

endmodule

FILE: src/srms_log2.sv
module srms_log2
  import srms_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  srms_rpt_t rpt,
  output srms_lvl_t lvl
);

  // Chunk scan stage.
  logic [PAD_W-1:0]        x_pad;
  logic [N_CHUNK-1:0]      c_nz;
  logic [CPOS_W-1:0]       c_pos [0:N_CHUNK-1];
  logic                    p1_v;
  logic [PAD_W-1:0]        p1_x;
  logic [N_CHUNK-1:0]      p1_nz;
  logic [CPOS_W-1:0]       p1_pos [0:N_CHUNK-1];

  // Top-bit select stage.
  logic [TOP_W-1:0]        top_sel;
  logic                    p2_v;
  logic [PAD_W-1:0]        p2_x;
  logic [TOP_W-1:0]        p2_top;
  logic                    p2_zero;
  logic [MANT_W-1:0]       norm_m;

  // Squaring stages; index 0 holds the normalized mantissa.
  logic [FRAC_W:0]         sq_v;
  logic [MANT_W-1:0]       sq_m    [0:FRAC_W];
  logic [FRAC_W-1:0]       sq_f    [0:FRAC_W];
  logic [TOP_W-1:0]        sq_top  [0:FRAC_W];
  logic                    sq_zero [0:FRAC_W];
  logic [MANT_W-1:0]       m_nx    [0:FRAC_W-1];
  logic [FRAC_W-1:0]       f_nx    [0:FRAC_W-1];

  // Difference and scaling stages.
  logic                    d_v;
  logic                    d_zero;
  logic [D_W-1:0]          d_val;
  logic [PROD_W-1:0]       prod;
  logic [PROD_W-33:0]      mag;
  logic signed [OUT_W-1:0] level_calc;

  // Per-chunk nonzero flag and highest set bit.
  assign x_pad = PAD_W'(rpt.sum);
  always_comb begin
    for (int c = 0; c < N_CHUNK; c++) begin
      c_nz[c]  = |x_pad[c*CHUNK_W +: CHUNK_W];
      c_pos[c] = '0;
      for (int i = 0; i < CHUNK_W; i++) begin
        if (x_pad[c*CHUNK_W + i]) c_pos[c] = CPOS_W'(i);
      end
    end
  end

  // Highest nonzero chunk gives the integer part of the log.
  always_comb begin
    top_sel = '0;
    for (int c = 0; c < N_CHUNK; c++) begin
      if (p1_nz[c]) top_sel = {CPOS_W'(c), p1_pos[c]};
    end
  end

  // Normalize to Q1.31, truncating the low bits.
  always_comb begin
    if (p2_top >= TOP_W'(31)) begin
      norm_m = MANT_W'(p2_x >> (p2_top - TOP_W'(31)));
    end else begin
      norm_m = MANT_W'(p2_x << (TOP_W'(31) - p2_top));
    end
  end

  // One squaring per stage; a result of 2.0 or more sets a fraction bit.
  always_comb begin
    logic [2*MANT_W-1:0] p;
    logic [MANT_W:0]     t;
    for (int k = 0; k < FRAC_W; k++) begin
      p = (2*MANT_W)'(sq_m[k]) * (2*MANT_W)'(sq_m[k]);
      t = p[2*MANT_W-1:MANT_W-1];
      if (t[MANT_W]) begin
        m_nx[k] = t[MANT_W:1];
        f_nx[k] = {sq_f[k][FRAC_W-2:0], 1'b1};
      end else begin
        m_nx[k] = t[MANT_W-1:0];
        f_nx[k] = {sq_f[k][FRAC_W-2:0], 1'b0};
      end
    end
  end

  // Convert the log difference to 1/256 dB and clamp.
  assign prod = PROD_W'(d_val) * PROD_W'(LOG_SCALE) + ROUND_HALF;
  assign mag  = prod[PROD_W-1:32];
  always_comb begin
    priority if (d_zero) begin
      level_calc = LEVEL_FLOOR;
    end else if (d_val[D_W-1] || (d_val == '0)) begin
      level_calc = '0;
    end else if (mag[PROD_W-33:FRAC_W] != '0) begin
      level_calc = LEVEL_FLOOR;
    end else begin
      level_calc = OUT_W'(0) - OUT_W'(mag[FRAC_W-1:0]);
    end
  end

  // Valid bits of every stage, and the finished level.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      sq_v <= '0;
      d_v  <= 1'b0;
      lvl  <= '0;
    end else if (adv) begin
      p1_v      <= rpt.valid;
      p2_v      <= p1_v;
      sq_v      <= {sq_v[FRAC_W-1:0], p2_v};
      d_v       <= sq_v[FRAC_W];
      lvl.valid <= d_v;
      lvl.level <= level_calc;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_x  <= x_pad;
      p1_nz <= c_nz;
      for (int c = 0; c < N_CHUNK; c++) begin
        p1_pos[c] <= c_pos[c];
      end
      p2_x       <= p1_x;
      p2_top     <= top_sel;
      p2_zero    <= (p1_nz == '0);
      sq_m[0]    <= norm_m;
      sq_f[0]    <= '0;
      sq_top[0]  <= p2_top;
      sq_zero[0] <= p2_zero;
      for (int k = 0; k < FRAC_W; k++) begin
        sq_m[k+1]    <= m_nx[k];
        sq_f[k+1]    <= f_nx[k];
        sq_top[k+1]  <= sq_top[k];
        sq_zero[k+1] <= sq_zero[k];
      end
      d_val  <= FULL_Q16 - D_W'({sq_top[FRAC_W], sq_f[FRAC_W]});
      d_zero <= sq_zero[FRAC_W];
    end
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import srms_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int LIMIT_NS = 10_000_000;
  localparam logic signed [OUT_W-1:0] DB_FLOOR = -17'sd65536;
  localparam longint FS_LOG2_Q16 = longint'(2 * SAMPLE_BITS - 2) * 65536;
  localparam logic [63:0] DB_PER_LOG2 = 64'd50504453;

  // Sample styles used to build random stretches of audio.
  typedef enum int {
    STYLE_SILENT,
    STYLE_FULL_SCALE,
    STYLE_SCALED,
    STYLE_NOISE
  } audio_style_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] report_interval = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [IN_W-1:0] sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] level_db;

  // Model state of the meter.
  logic [SQ_W-1:0] sq_ring [WINDOW];
  int unsigned ring_slot;
  logic [SUM_W-1:0] energy_sum;
  logic [15:0] samples_since_report;
  logic [CFG_W-1:0] meter_interval;

  logic signed [IN_W-1:0] pending_samples[$];
  logic signed [OUT_W-1:0] expected_levels[$];
  logic in_fire = 1'b0;
  int sender_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;

  sliding_rms_level_meter_core uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .report_interval(report_interval),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample(sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .level_db(level_db)
  );

  always #5 clk = ~clk;

  // Base-2 log in Q.16: integer part from the top set bit, fraction by
  // repeated squaring of the Q1.31 mantissa.
  function automatic longint log2_fixed(input logic [63:0] x);
    int top;
    logic [63:0] m;
    longint frac;
    top = 63;
    frac = 0;
    while (top > 0 && !x[top]) top--;
    m = (top >= 31) ? (x >> (top - 31)) : (x << (31 - top));
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return longint'(top) * 65536 + frac;
  endfunction

  // Window level in 1/256 dBFS for a given sum of squares.
  function automatic logic signed [OUT_W-1:0] dbfs_of(input logic [SUM_W-1:0] s);
    longint d;
    logic [63:0] mag;
    longint lvl;
    if (s == '0) return DB_FLOOR;
    d = log2_fixed(64'(WINDOW)) + FS_LOG2_Q16 - log2_fixed(64'(s));
    if (d <= 0) return '0;
    mag = (64'(d) * DB_PER_LOG2 + 64'h8000_0000) >> 32;
    if (mag >= 64'd65536) return DB_FLOOR;
    lvl = -longint'(mag);
    return lvl[OUT_W-1:0];
  endfunction

  // Advance the model by one accepted sample and queue any level it reports.
  task automatic meter_step(input logic signed [IN_W-1:0] s);
    logic signed [IN_W-1:0] v;
    logic [MAG_W-1:0] mag;
    logic [SQ_W-1:0] sq;
    v = s;
    if (v == -24'sd8388608) v = -24'sd8388607;
    mag = v[IN_W-1] ? MAG_W'(-v) : MAG_W'(v);
    sq = SQ_W'(mag) * SQ_W'(mag);
    energy_sum = energy_sum + SUM_W'(sq) - SUM_W'(sq_ring[ring_slot]);
    sq_ring[ring_slot] = sq;
    ring_slot = (ring_slot == WINDOW - 1) ? 0 : ring_slot + 1;
    samples_since_report = samples_since_report + 16'd1;
    if (samples_since_report >= meter_interval) begin
      samples_since_report = '0;
      expected_levels.push_back(dbfs_of(energy_sum));
    end
  endtask

  task automatic report_mismatch(input string what, input logic signed [OUT_W-1:0] got,
                                 input logic signed [OUT_W-1:0] want);
    $display("%0t: %s: level_db got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Acceptance of a sample word drives the model.
  always @(posedge clk) begin
    in_fire <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) meter_step(sample);
  end

  // Sample driver: holds each word until taken, idles at random between words.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_samples.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_valid <= 1'b1;
        sample <= pending_samples.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Level monitor: random back-pressure, checks each accepted word in order.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_levels.size() == 0) begin
        report_mismatch("unexpected level word", level_db, '0);
      end else if (level_db !== expected_levels[0]) begin
        report_mismatch("level mismatch", level_db, expected_levels.pop_front());
      end else begin
        void'(expected_levels.pop_front());
      end
    end
  end

  function automatic logic signed [IN_W-1:0] draw_sample(input audio_style_e style,
                                                         input int bits);
    logic [31:0] raw;
    raw = $urandom();
    case (style)
      STYLE_SILENT: begin
        return '0;
      end
      STYLE_FULL_SCALE: begin
        case ($urandom_range(2))
          0: return 24'sd8388607;
          1: return -24'sd8388607;
          default: return -24'sd8388608;
        endcase
      end
      STYLE_SCALED: begin
        return IN_W'($signed(raw << (32 - bits)) >>> (32 - bits));
      end
      default: begin
        return raw[IN_W-1:0];
      end
    endcase
  endfunction

  task automatic queue_stretch(input audio_style_e style, input int count);
    int bits;
    bits = $urandom_range(1, IN_W);
    repeat (count) pending_samples.push_back(draw_sample(style, bits));
  endtask

  // Random audio made of stretches of differing loudness.
  task automatic queue_random_audio(input int total);
    int len;
    int pick;
    audio_style_e style;
    while (total > 0) begin
      len = $urandom_range(1, 400);
      if (len > total) len = total;
      pick = $urandom_range(99);
      if (pick < 5) style = STYLE_SILENT;
      else if (pick < 15) style = STYLE_FULL_SCALE;
      else if (pick < 75) style = STYLE_SCALED;
      else style = STYLE_NOISE;
      queue_stretch(style, len);
      total -= len;
    end
  endtask

  // Wait until every queued word is taken and every level has come back,
  // then give the pipeline time to finish samples that report nothing.
  task automatic drain;
    while (pending_samples.size() > 0 || in_valid) @(posedge clk);
    while (expected_levels.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_interval(input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    report_interval <= value;
    do @(posedge clk); while (!cfg_ready);
    meter_interval = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int sender_pct, input int recv_pct);
    sender_idle_pct = sender_pct;
    recv_idle_pct = recv_pct;
  endtask

  initial begin
    foreach (sq_ring[i]) sq_ring[i] = '0;
    ring_slot = 0;
    energy_sum = '0;
    samples_since_report = '0;
    meter_interval = INTERVAL_RESET;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words, reporting every sample: empty window first, then the
    // extremes of the sample range including the negative full-scale code.
    set_idling(36, 48);
    write_interval(16'd1);
    pending_samples = '{24'sd0, 24'sd0, -24'sd8388608, 24'sd8388607, -24'sd8388607,
                        24'sd1, -24'sd1, 24'sh400000, -24'sh400000, 24'sd0,
                        24'sh555555, -24'sh2AAAAB};
    drain();
    // An interval of zero behaves like one.
    write_interval(16'd0);
    pending_samples = '{24'sd8388607, -24'sd8388608, 24'sd5, 24'sd0};
    drain();
    write_interval(INTERVAL_RESET);
    queue_random_audio(350);
    drain();

    // Longest interval, then lowered below the count already reached.
    set_idling(48, 36);
    write_interval(16'hFFFF);
    queue_random_audio(100);
    drain();
    write_interval(16'd7);
    queue_random_audio(300);
    drain();
    // A long stretch of full-scale audio pushes the level well up the scale.
    write_interval(16'd100);
    queue_stretch(STYLE_FULL_SCALE, 500);
    queue_random_audio(150);
    drain();

    // No idling on either side, a few random intervals.
    set_idling(0, 0);
    repeat (3) begin
      write_interval(CFG_W'($urandom_range(2, 400)));
      queue_random_audio(110);
      drain();
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("timeout with %0d levels outstanding", expected_levels.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
